// ===== src/ltm_pkg.sv =====
`timescale 1ns / 1ps

package ltm_pkg;

  // Defaults for the top-level parameters.
  localparam int WAYS_DEF     = 16;
  localparam int KEY_BITS_DEF = 64;

  // Fixed field widths of the stream items.
  localparam int CMD_W       = 2;
  localparam int WAY_FIELD_W = 4;
  localparam int KEY_FIELD_W = 64;
  localparam int NWAYS_W     = 5;

  // Stream data buses: way in the low nibble, key above it, zero padded to bytes.
  localparam int TDATA_W = 72;

  localparam logic [NWAYS_W-1:0] NWAYS_RESET = NWAYS_W'(16);

  // Command codes carried in the input tuser field.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

endpackage

// ===== src/ltm_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ltm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ltm_cmp.sv =====
`timescale 1ns / 1ps

// Match comparator of the loser tree. An exhausted way loses to every live
// way, and live ways compare as signed keys. On a tie the climbing way (a)
// does not lose.
module ltm_cmp #(
  parameter int KEY_BITS = 64
) (
  input  logic                       a_exh_i,
  input  logic signed [KEY_BITS-1:0] a_key_i,
  input  logic                       b_exh_i,
  input  logic signed [KEY_BITS-1:0] b_key_i,
  output logic                       a_loses_o
);

  always_comb begin
    if (a_exh_i || b_exh_i) begin
      a_loses_o = a_exh_i && !b_exh_i;
    end else begin
      a_loses_o = a_key_i > b_key_i;
    end
  end

endmodule

// ===== src/loser_tree_kway_merge_core.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake         Payload, lowest bits first
// s_axis   in   tvalid tready     tdata: way, key, pad; tuser: cmd; tlast: is_end
// m_axis   out  tvalid tready     tdata: winner_way, winner_key, pad; tuser: all_done
// cfg      in   cfg_we_i          cfg_wdata_i: n_ways
//
// A load or an unused command completes on its transfer and leaves the block idle. A next-key
// command replays its winner from its leaf before its result, climbing at most four levels
// at sixteen ways; a build climbs each of its ways in turn, from way n-1 down to 0.
// Each level is one node RAM read and one head RAM read, both registered, into one comparator.
// Reset clears all control state and the valid bits of both RAMs, so no clearing pass runs.
// A result that waits on m_axis stalls only a build or next-key command at its last cycle.
module loser_tree_kway_merge_core #(
  parameter int WAYS     = ltm_pkg::WAYS_DEF,
  parameter int KEY_BITS = ltm_pkg::KEY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           cfg_we_i,
  input  logic [ltm_pkg::NWAYS_W-1:0]    cfg_wdata_i,     // n_ways

  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ltm_pkg::TDATA_W-1:0]    s_axis_tdata,    // way, key, zero pad
  input  logic [ltm_pkg::CMD_W-1:0]      s_axis_tuser,    // cmd
  input  logic                           s_axis_tlast,    // is_end

  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ltm_pkg::TDATA_W-1:0]    m_axis_tdata,    // winner_way, winner_key, pad
  output logic                           m_axis_tuser     // all_done
);

  localparam int WAY_W  = $clog2(WAYS);
  localparam int NODE_W = $clog2(WAYS + 1);
  localparam int WF_W   = ltm_pkg::WAY_FIELD_W;
  localparam int KF_W   = ltm_pkg::KEY_FIELD_W;
  localparam int PAD_W  = ltm_pkg::TDATA_W - WF_W - KF_W;

  // A node that holds no way carries this code.
  localparam logic [NODE_W-1:0] EMPTY = NODE_W'(WAYS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RD_NODE,
    ST_CMP,
    ST_REPORT
  } state_e;

  // Input fields.
  logic [WF_W-1:0]              in_way;
  logic [KF_W-1:0]              in_key;
  logic [WAY_W-1:0]             way_idx;
  logic                         way_ok;
  logic                         s_acc;

  assign in_way  = s_axis_tdata[WF_W-1:0];
  assign in_key  = s_axis_tdata[WF_W+KF_W-1:WF_W];
  assign way_idx = WAY_W'(in_way);
  assign way_ok  = 32'(in_way) < 32'(WAYS);
  assign s_acc   = s_axis_tvalid && s_axis_tready;

  // Registers.
  state_e                       state_q, state_d;
  logic [ltm_pkg::NWAYS_W-1:0]  n_ways_q;
  logic [NODE_W-1:0]            n_q, n_d;
  logic                         is_bld_q, is_bld_d;
  logic [WAY_W-1:0]             bld_q, bld_d;
  logic [NODE_W-1:0]            s_q, s_d;
  logic [WAY_W-1:0]             t_q, t_d;
  logic [NODE_W-1:0]            lsr_q, lsr_d;
  logic                         cur_exh_q, cur_exh_d;
  logic signed [KEY_BITS-1:0]   cur_key_q, cur_key_d;
  logic                         end_q, end_d;
  logic [KEY_BITS-1:0]          key_q, key_d;
  logic [NODE_W-1:0]            winner_q, winner_d;
  logic [WAYS-1:0]              head_vld_q, head_vld_d;
  logic [WAYS-1:0]              node_vld_q, node_vld_d;
  logic                         head_rvld_q, node_rvld_q;
  logic                         m_valid_q, m_valid_d;
  logic                         m_done_q, m_done_d;
  logic [WF_W-1:0]              m_way_q, m_way_d;
  logic [KF_W-1:0]              m_key_q, m_key_d;

  // RAM ports.
  logic                         head_we;
  logic [WAY_W-1:0]             head_waddr, head_raddr;
  logic [KEY_BITS:0]            head_wdata, head_rdata;
  logic                         node_we;
  logic [WAY_W-1:0]             node_waddr, node_raddr;
  logic [NODE_W-1:0]            node_wdata, node_rdata;

  // Head as read back: an entry never written reads as live.
  logic                         rd_exh;
  logic signed [KEY_BITS-1:0]   rd_key;
  logic                         a_loses;

  logic [NODE_W-1:0]            n_used;
  logic [NODE_W:0]              t_sum;
  logic [WAY_W-1:0]             t_start;
  logic [WAY_W-1:0]             t_next;
  logic [NODE_W-1:0]            node_loser;
  logic                         fin;

  assign rd_exh = head_rvld_q && head_rdata[KEY_BITS];
  assign rd_key = head_rdata[KEY_BITS-1:0];

  always_comb begin
    if (n_ways_q == '0) begin
      n_used = NODE_W'(1);
    end else if (32'(n_ways_q) > 32'(WAYS)) begin
      n_used = NODE_W'(WAYS);
    end else begin
      n_used = NODE_W'(n_ways_q);
    end
  end

  // First node a way meets on its climb.
  assign t_sum      = (NODE_W+1)'(s_q) + (NODE_W+1)'(n_q);
  assign t_start    = WAY_W'(t_sum >> 1);
  assign t_next     = t_q >> 1;
  assign node_loser = node_rvld_q ? node_rdata : EMPTY;

  ltm_ram #(
    .WIDTH (KEY_BITS + 1),
    .DEPTH (WAYS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  ltm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (WAYS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  ltm_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .a_exh_i   (cur_exh_q),
    .a_key_i   (cur_key_q),
    .b_exh_i   (rd_exh),
    .b_key_i   (rd_key),
    .a_loses_o (a_loses)
  );

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    is_bld_d   = is_bld_q;
    bld_d      = bld_q;
    s_d        = s_q;
    t_d        = t_q;
    lsr_d      = lsr_q;
    cur_exh_d  = cur_exh_q;
    cur_key_d  = cur_key_q;
    end_d      = end_q;
    key_d      = key_q;
    winner_d   = winner_q;
    head_vld_d = head_vld_q;
    node_vld_d = node_vld_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_done_d   = m_done_q;
    m_way_d    = m_way_q;
    m_key_d    = m_key_q;
    head_we    = 1'b0;
    head_waddr = '0;
    head_wdata = '0;
    head_raddr = '0;
    node_we    = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    node_raddr = '0;
    fin        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          case (s_axis_tuser)
            ltm_pkg::CMD_LOAD: begin
              if (way_ok) begin
                head_we             = 1'b1;
                head_waddr          = way_idx;
                head_wdata          = {s_axis_tlast, KEY_BITS'(in_key)};
                head_vld_d[way_idx] = 1'b1;
              end
            end
            ltm_pkg::CMD_BUILD: begin
              // Empty every node at once, then climb ways n-1 down to 0.
              node_vld_d = '0;
              n_d        = n_used;
              is_bld_d   = 1'b1;
              bld_d      = WAY_W'(n_used - NODE_W'(1));
              s_d        = n_used - NODE_W'(1);
              head_raddr = WAY_W'(n_used - NODE_W'(1));
              state_d    = ST_SETUP;
            end
            ltm_pkg::CMD_NEXT: begin
              n_d      = n_used;
              is_bld_d = 1'b0;
              end_d    = s_axis_tlast;
              key_d    = KEY_BITS'(in_key);
              s_d      = winner_q;
              if (winner_q == EMPTY) begin
                state_d = ST_REPORT;
              end else begin
                head_raddr = WAY_W'(winner_q);
                state_d    = ST_SETUP;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_SETUP: begin
        if (!is_bld_q && rd_exh) begin
          // The winner is already exhausted: nothing changes.
          cur_exh_d = 1'b1;
          state_d   = ST_REPORT;
        end else begin
          if (!is_bld_q) begin
            // Replace the winner's head, then replay from its leaf.
            head_we                           = 1'b1;
            head_waddr                        = WAY_W'(s_q);
            head_wdata                        = {end_q, key_q};
            head_vld_d[WAY_W'(s_q)]           = 1'b1;
            cur_exh_d                         = end_q;
            cur_key_d                         = key_q;
          end else begin
            cur_exh_d = rd_exh;
            cur_key_d = rd_key;
          end
          if (t_start == '0) begin
            fin = 1'b1;
          end else begin
            node_raddr = t_start;
            t_d        = t_start;
            state_d    = ST_RD_NODE;
          end
        end
      end

      ST_RD_NODE: begin
        if (node_loser == EMPTY) begin
          // Park the climbing way in the empty node; the climb ends here.
          node_we          = 1'b1;
          node_waddr       = t_q;
          node_wdata       = s_q;
          node_vld_d[t_q]  = 1'b1;
          s_d              = EMPTY;
          fin              = 1'b1;
        end else begin
          lsr_d      = node_loser;
          head_raddr = WAY_W'(node_loser);
          state_d    = ST_CMP;
        end
      end

      ST_CMP: begin
        if (a_loses) begin
          // The climbing way stays as loser here and the stored way climbs on.
          node_we    = 1'b1;
          node_waddr = t_q;
          node_wdata = s_q;
          s_d        = lsr_q;
          cur_exh_d  = rd_exh;
          cur_key_d  = rd_key;
        end
        if (t_next == '0) begin
          fin = 1'b1;
        end else begin
          node_raddr = t_next;
          t_d        = t_next;
          state_d    = ST_RD_NODE;
        end
      end

      ST_REPORT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          if (s_q == EMPTY || cur_exh_q) begin
            m_done_d = 1'b1;
            m_way_d  = '0;
            m_key_d  = '0;
          end else begin
            m_done_d = 1'b0;
            m_way_d  = WF_W'(s_q);
            m_key_d  = KF_W'(cur_key_q);
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // End of one climb: record the winner, then start the next way of a
    // build or go report.
    if (fin) begin
      winner_d = s_d;
      if (is_bld_q && bld_q != '0) begin
        bld_d      = bld_q - WAY_W'(1);
        s_d        = NODE_W'(bld_q - WAY_W'(1));
        head_raddr = bld_q - WAY_W'(1);
        state_d    = ST_SETUP;
      end else begin
        state_d = ST_REPORT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_ways_q    <= ltm_pkg::NWAYS_RESET;
      n_q         <= NODE_W'(1);
      is_bld_q    <= 1'b0;
      bld_q       <= '0;
      s_q         <= '0;
      t_q         <= '0;
      lsr_q       <= '0;
      cur_exh_q   <= 1'b0;
      cur_key_q   <= '0;
      end_q       <= 1'b0;
      key_q       <= '0;
      winner_q    <= '0;
      head_vld_q  <= '0;
      node_vld_q  <= '0;
      head_rvld_q <= 1'b0;
      node_rvld_q <= 1'b0;
      m_valid_q   <= 1'b0;
      m_done_q    <= 1'b0;
      m_way_q     <= '0;
      m_key_q     <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        n_ways_q <= cfg_wdata_i;
      end
      n_q         <= n_d;
      is_bld_q    <= is_bld_d;
      bld_q       <= bld_d;
      s_q         <= s_d;
      t_q         <= t_d;
      lsr_q       <= lsr_d;
      cur_exh_q   <= cur_exh_d;
      cur_key_q   <= cur_key_d;
      end_q       <= end_d;
      key_q       <= key_d;
      winner_q    <= winner_d;
      head_vld_q  <= head_vld_d;
      node_vld_q  <= node_vld_d;
      head_rvld_q <= head_vld_q[head_raddr];
      node_rvld_q <= node_vld_q[node_raddr];
      m_valid_q   <= m_valid_d;
      m_done_q    <= m_done_d;
      m_way_q     <= m_way_d;
      m_key_q     <= m_key_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, m_key_q, m_way_q};
  assign m_axis_tuser  = m_done_q;

endmodule

// ===== dv/loser_tree_kway_merge_core_tb.sv =====
`timescale 1ns / 1ps

module loser_tree_kway_merge_core_tb;

  localparam int NUM_WAYS = 16;
  localparam logic [4:0] EMPTY_SLOT = 5'd16;
  localparam logic [ltm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [63:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam int ITEM_TARGET = 1050;
  localparam int STALL_LIMIT = 4000;
  // The longest command at sixteen ways is a build, drained before this wait;
  // a load or an unused command ends on its transfer, so this covers any tail.
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [3:0]         way;
    logic signed [63:0] key;
    logic               done;
  } winner_t;

  // Scoreboard: mirrors the loser tree at transfer level and holds the
  // winners that the block still owes on the result stream.
  class merge_order_scoreboard;
    logic signed [63:0] head_key [NUM_WAYS];
    bit                 spent    [NUM_WAYS];
    logic [4:0]         loser    [NUM_WAYS];
    logic [4:0]         champ;
    int unsigned        live;
    logic [4:0]         n_ways;
    winner_t            owed_q [$];
    int errors, n_loads, n_builds, n_nexts, n_unused, n_results, n_done;

    function new();
      foreach (loser[i]) begin
        head_key[i] = '0;
        spent[i]    = 1'b0;
        loser[i]    = EMPTY_SLOT;
      end
      champ  = '0;
      live   = 0;
      n_ways = ltm_pkg::NWAYS_RESET;
      errors = 0;
      n_loads = 0; n_builds = 0; n_nexts = 0; n_unused = 0;
      n_results = 0; n_done = 0;
    endfunction

    function int used_ways();
      if (n_ways == 0) return 1;
      if (n_ways > NUM_WAYS) return NUM_WAYS;
      return int'(n_ways);
    endfunction

    // True when way a has to yield to way b. Exhausted ways lose to live
    // ones, two exhausted ways tie, and a tie keeps the climbing way.
    function bit gives_way(logic [4:0] a, logic [4:0] b);
      if (spent[a] || spent[b]) return spent[a] && !spent[b];
      return head_key[a] > head_key[b];
    endfunction

    // Walk from the leaf of way start toward the root, swapping with any
    // node that holds a stronger way. An empty node parks the climber.
    function void climb(logic [4:0] start, int n);
      logic [4:0] s, tmp;
      int t;
      s = start;
      t = (int'(s) + n) / 2;
      while (t > 0 && t < NUM_WAYS) begin
        if (s >= EMPTY_SLOT) break;
        if (loser[t] >= EMPTY_SLOT || gives_way(s, loser[t])) begin
          tmp      = loser[t];
          loser[t] = s;
          s        = tmp;
        end
        t = t / 2;
      end
      loser[0] = s;
      champ    = s;
    endfunction

    function winner_t standing();
      winner_t r;
      if (champ >= EMPTY_SLOT || spent[champ]) begin
        r = '{way: '0, key: '0, done: 1'b1};
      end else begin
        r = '{way: champ[3:0], key: head_key[champ], done: 1'b0};
      end
      return r;
    endfunction

    function logic signed [63:0] lead_key();
      winner_t r;
      r = standing();
      return r.key;
    endfunction

    function void owe(winner_t r);
      owed_q.push_back(r);
      if (r.done) n_done++;
    endfunction

    // Called for every transfer accepted on the input stream.
    function void apply_command(logic [ltm_pkg::CMD_W-1:0] cmd, logic [3:0] way,
                                logic signed [63:0] key, logic last);
      int n;
      logic [4:0] w;
      n = used_ways();
      case (cmd)
        ltm_pkg::CMD_LOAD: begin
          n_loads++;
          spent[way] = last;
          if (!last) head_key[way] = key;
        end
        ltm_pkg::CMD_BUILD: begin
          n_builds++;
          foreach (loser[i]) loser[i] = EMPTY_SLOT;
          live = 0;
          for (int i = 0; i < n; i++) if (!spent[i]) live++;
          for (int i = n; i > 0; i--) climb(5'(i - 1), n);
          owe(standing());
        end
        ltm_pkg::CMD_NEXT: begin
          n_nexts++;
          w = champ;
          if (w < EMPTY_SLOT && !spent[w]) begin
            if (last) begin
              spent[w] = 1'b1;
              if (live > 0) live--;
            end else begin
              head_key[w] = key;
            end
            climb(w, n);
          end
          owe(standing());
        end
        default: n_unused++;
      endcase
    endfunction

    // Called for every transfer accepted on the result stream.
    function void check_winner(logic [3:0] way, logic signed [63:0] key, logic done);
      winner_t exp_r;
      n_results++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result way=%0d key=%0d done=%0b", $time, way, key, done);
        return;
      end
      exp_r = owed_q.pop_front();
      if (way !== exp_r.way) begin
        errors++;
        $display("%0t: winner_way mismatch, expected %0d actual %0d", $time, exp_r.way, way);
      end
      if (key !== exp_r.key) begin
        errors++;
        $display("%0t: winner_key mismatch, expected %0d actual %0d", $time, exp_r.key, key);
      end
      if (done !== exp_r.done) begin
        errors++;
        $display("%0t: all_done mismatch, expected %0b actual %0b", $time, exp_r.done, done);
      end
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [ltm_pkg::NWAYS_W-1:0]   cfg_wdata_i = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ltm_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
  logic [ltm_pkg::CMD_W-1:0]     s_axis_tuser = '0;
  logic                          s_axis_tlast = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ltm_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                          m_axis_tuser;

  merge_order_scoreboard sb;
  bit no_idle = 1'b0;
  int items_sent = 0;
  int phases_run = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int cfg_plan [10] = '{1, 16, 0, 20, 31, 2, 3, 7, 8, 9};

  loser_tree_kway_merge_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none in no-idle stretches.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [63:0] gen_key();
    case ($urandom_range(0, 9))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return 64'(signed'($urandom_range(0, 6)) - 3);
      3, 4, 5: return 64'(signed'($urandom_range(0, 200000)) - 100000);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result side: random back-pressure.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_winner(m_axis_tdata[3:0], m_axis_tdata[67:4], m_axis_tuser);
  end

  // Watchdog on cycles without any transfer on either stream.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one command and hold it until the block takes the transfer.
  task automatic send_item(logic [ltm_pkg::CMD_W-1:0] cmd, logic [3:0] way,
                           logic signed [63:0] key, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, key, way};
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_command(cmd, way, key, last);
    items_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic set_merge_ways(logic [ltm_pkg::NWAYS_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.n_ways = value;
  endtask

  // One merge: load the heads, build, then mostly sorted next keys with
  // some noise mixed in.
  task automatic run_merge_phase(int nexts);
    int n_eff, end_pct, r;
    logic signed [63:0] cur, nxt, step;
    n_eff = sb.used_ways();
    case ($urandom_range(0, 3))
      0: end_pct = 0;
      1: end_pct = 10;
      2: end_pct = 30;
      default: end_pct = 100;
    endcase
    for (int w = 0; w < n_eff; w++)
      send_item(ltm_pkg::CMD_LOAD, 4'(w), gen_key(), $urandom_range(0, 99) < end_pct);
    if (n_eff < NUM_WAYS && $urandom_range(0, 1) == 1)
      send_item(ltm_pkg::CMD_LOAD, 4'($urandom_range(n_eff, NUM_WAYS - 1)), gen_key(),
                1'b0);
    send_item(ltm_pkg::CMD_BUILD, 4'($urandom), gen_key(), 1'($urandom));
    repeat (nexts) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        cur  = sb.lead_key();
        step = ($urandom_range(0, 3) == 0) ? 64'sd0 : 64'($urandom_range(1, 5000));
        nxt  = cur + step;
        if (nxt < cur) nxt = KEY_MAX;
        send_item(ltm_pkg::CMD_NEXT, 4'($urandom), nxt, $urandom_range(0, 11) == 0);
      end else if (r < 80) begin
        send_item(ltm_pkg::CMD_NEXT, 4'($urandom), gen_key(), 1'b0);
      end else if (r < 86) begin
        send_item(ltm_pkg::CMD_NEXT, 4'($urandom), gen_key(), 1'b1);
      end else if (r < 90) begin
        send_item(CMD_UNUSED, 4'($urandom), gen_key(), 1'($urandom));
      end else if (r < 95) begin
        send_item(ltm_pkg::CMD_LOAD, 4'($urandom), gen_key(), $urandom_range(0, 3) == 0);
      end else if (r < 98) begin
        send_item(ltm_pkg::CMD_BUILD, 4'($urandom), gen_key(), 1'($urandom));
      end else begin
        // Let the block run dry before the next command.
        drain_results();
      end
    end
  endtask

  initial begin
    int v;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset way count of sixteen. Every head is
    // written before the first build so no unloaded head is ever compared.
    send_item(ltm_pkg::CMD_LOAD, 4'd0, KEY_MAX, 1'b0);
    send_item(ltm_pkg::CMD_LOAD, 4'd1, KEY_MIN, 1'b0);
    send_item(ltm_pkg::CMD_LOAD, 4'd2, -64'sd1, 1'b0);
    send_item(ltm_pkg::CMD_LOAD, 4'd3, 64'sd0, 1'b0);
    send_item(ltm_pkg::CMD_LOAD, 4'd4, 64'sd0, 1'b0);
    for (int w = 5; w < NUM_WAYS; w++)
      send_item(ltm_pkg::CMD_LOAD, 4'(w), gen_key(), 1'b0);
    send_item(ltm_pkg::CMD_LOAD, 4'd5, gen_key(), 1'b1);
    send_item(ltm_pkg::CMD_BUILD, 4'hf, KEY_MAX, 1'b1);
    // Equal next key: the climbing way keeps the lead.
    send_item(ltm_pkg::CMD_NEXT, 4'd0, KEY_MIN, 1'b0);
    send_item(ltm_pkg::CMD_NEXT, 4'd7, gen_key(), 1'b1);
    send_item(ltm_pkg::CMD_NEXT, 4'd0, KEY_MAX, 1'b0);
    send_item(CMD_UNUSED, 4'ha, gen_key(), 1'b1);
    // A load after the build changes the head only; the tree is not replayed.
    send_item(ltm_pkg::CMD_LOAD, 4'd1, -64'sd5, 1'b0);
    send_item(ltm_pkg::CMD_NEXT, 4'd3, KEY_MAX, 1'b0);
    send_item(ltm_pkg::CMD_BUILD, 4'd0, 64'sd0, 1'b0);

    // Random merges over a range of way counts, out-of-range ones included.
    while (items_sent < ITEM_TARGET) begin
      if (phases_run < 10) begin
        v = cfg_plan[phases_run];
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: v = 1;
          3, 4, 5: v = 16;
          6: v = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
          default: v = $urandom_range(2, 15);
        endcase
      end
      no_idle = (phases_run % 5 == 3);
      set_merge_ways(v[ltm_pkg::NWAYS_W-1:0]);
      run_merge_phase($urandom_range(8, 40));
      phases_run++;
    end
    no_idle = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.owed_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected winners never arrived", $time, sb.owed_q.size());
    end

    $display("Run covered %0d head loads, %0d builds, %0d next-key and %0d unused commands",
             sb.n_loads, sb.n_builds, sb.n_nexts, sb.n_unused);
    $display("over %0d way settings; %0d winners checked, %0d of them with all ways done.",
             phases_run, sb.n_results, sb.n_done);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
